// ===== rtl/core/etre_pkg.sv =====
// Shared types and constants for the EIGRP TLV route extractor.
`timescale 1ns / 1ps
`default_nettype none

package etre_pkg;

  // One packet byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } etre_in_t;

  // One extracted record as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  opcode_value;
    logic [15:0] as_number;
    logic [15:0] router_id;
    logic [31:0] header_flags;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [23:0] route_mtu;
    logic [7:0]  route_hops;
    logic [7:0]  prefix_length;
    logic [31:0] destination;
  } etre_out_t;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_UPDATE,
    MODE_HELLO,
    MODE_SKIP
  } parse_mode_t;

  // What the back end does with the byte carried in an operation.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_OPCODE,
    ACT_FLAGS,
    ACT_IDENT,
    ACT_CLEAR,
    ACT_WORD,
    ACT_PREFIX,
    ACT_DEST
  } byte_act_t;

  // Classified byte passed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;
    byte_act_t  act;
    logic [1:0] idx;
    logic       emit;
    logic [1:0] kind;
  } byte_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ROUTE   = 2'd1;
  localparam logic [1:0] KIND_PARAMS  = 2'd2;
  localparam logic [1:0] KIND_VERSION = 2'd3;

  localparam logic [7:0]  OPC_UPDATE    = 8'd1;
  localparam logic [7:0]  OPC_HELLO     = 8'd5;
  localparam logic [15:0] ROUTE_TYPE    = 16'h0102;
  localparam logic [15:0] ROUTE_MIN_LEN = 16'd25;
  localparam logic [4:0]  HDR_LAST_POS  = 5'd19;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

endpackage

`default_nettype wire

// ===== rtl/core/etre_front.sv =====
// Front end: tracks packet position and classifies each byte into an operation.
`timescale 1ns / 1ps
`default_nettype none

module etre_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  input  wire etre_pkg::etre_in_t byte_data,
  input  wire logic              q_full,
  output logic                   push,
  output etre_pkg::byte_op_t     op
);

  etre_pkg::parse_mode_t mode, mode_next;
  logic [4:0]  pos, pos_next;
  logic [15:0] off, off_next;
  logic [15:0] tlv_type, tlv_type_next;
  logic [15:0] tlv_len, tlv_len_next;
  logic        phase, phase_next;
  logic [7:0]  opcode, opcode_next;

  logic        accept;
  logic [7:0]  b;
  logic [16:0] off_p1;
  logic [15:0] len_full;
  logic [1:0]  word_sel;
  logic        is_route;

  assign accept   = byte_valid && !q_full;
  assign b        = byte_data.data_byte;
  assign off_p1   = {1'b0, off} + 17'd1;
  assign len_full = {tlv_len[15:8], b};
  assign word_sel = off[3:2] - 2'd1;
  assign is_route = (tlv_type == etre_pkg::ROUTE_TYPE);

  always_comb begin
    mode_next     = mode;
    pos_next      = pos;
    off_next      = off;
    tlv_type_next = tlv_type;
    tlv_len_next  = tlv_len;
    phase_next    = phase;
    opcode_next   = opcode;
    op.data       = b;
    op.act        = etre_pkg::ACT_NONE;
    op.idx        = 2'd0;
    op.emit       = 1'b0;
    op.kind       = etre_pkg::KIND_HEADER;

    unique case (mode)
      etre_pkg::MODE_HEADER: begin
        if (pos == 5'd1) begin
          opcode_next = b;
          op.act      = etre_pkg::ACT_OPCODE;
        end else if (pos >= 5'd4 && pos <= 5'd7) begin
          op.act = etre_pkg::ACT_FLAGS;
        end else if (pos >= 5'd16 && pos <= 5'd19) begin
          op.act = etre_pkg::ACT_IDENT;
        end
        if (pos >= etre_pkg::HDR_LAST_POS) begin
          pos_next   = 5'd0;
          off_next   = 16'd0;
          phase_next = 1'b0;
          op.emit    = 1'b1;
          op.kind    = etre_pkg::KIND_HEADER;
          if (opcode_next == etre_pkg::OPC_UPDATE) begin
            mode_next = etre_pkg::MODE_UPDATE;
          end else if (opcode_next == etre_pkg::OPC_HELLO) begin
            mode_next = etre_pkg::MODE_HELLO;
          end else begin
            mode_next = etre_pkg::MODE_SKIP;
          end
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      etre_pkg::MODE_UPDATE: begin
        if (off == 16'd0) begin
          op.act        = etre_pkg::ACT_CLEAR;
          tlv_type_next = {b, 8'h00};
          off_next      = 16'd1;
        end else if (off == 16'd1) begin
          tlv_type_next = {tlv_type[15:8], b};
          off_next      = 16'd2;
        end else if (off == 16'd2) begin
          tlv_len_next = {b, 8'h00};
          off_next     = 16'd3;
        end else if (off == 16'd3) begin
          tlv_len_next = len_full;
          // A length too small to cover its own TLV header abandons the packet.
          if (len_full < 16'd4) begin
            mode_next = etre_pkg::MODE_SKIP;
            off_next  = 16'd0;
          end else if (len_full == 16'd4) begin
            off_next = 16'd0;
          end else begin
            off_next = 16'd4;
          end
        end else begin
          if (is_route) begin
            if (off <= 16'd19) begin
              op.act = etre_pkg::ACT_WORD;
              op.idx = word_sel;
            end else if (off == 16'd24) begin
              op.act = etre_pkg::ACT_PREFIX;
            end else if (off >= 16'd25 && off <= 16'd28) begin
              op.act = etre_pkg::ACT_DEST;
              op.idx = off[1:0] - 2'd1;
            end
          end
          if (off_p1 >= {1'b0, tlv_len}) begin
            off_next = 16'd0;
            if (is_route && tlv_len >= etre_pkg::ROUTE_MIN_LEN) begin
              op.emit = 1'b1;
              op.kind = etre_pkg::KIND_ROUTE;
            end
          end else begin
            off_next = off_p1[15:0];
          end
        end
      end
      etre_pkg::MODE_HELLO: begin
        if (off == 16'd0) begin
          op.act = etre_pkg::ACT_CLEAR;
        end
        if (!phase) begin
          if (off >= 16'd4 && off <= 16'd7) begin
            op.act = etre_pkg::ACT_WORD;
            op.idx = 2'd0;
          end else if (off == 16'd8 || off == 16'd9) begin
            op.act = etre_pkg::ACT_WORD;
            op.idx = 2'd1;
          end else if (off == 16'd10 || off == 16'd11) begin
            op.act = etre_pkg::ACT_WORD;
            op.idx = 2'd2;
          end
          if (off >= 16'd11) begin
            off_next   = 16'd0;
            phase_next = 1'b1;
            op.emit    = 1'b1;
            op.kind    = etre_pkg::KIND_PARAMS;
          end else begin
            off_next = off_p1[15:0];
          end
        end else begin
          if (off >= 16'd4 && off <= 16'd7) begin
            op.act = etre_pkg::ACT_WORD;
            op.idx = 2'd0;
          end
          if (off >= 16'd7) begin
            off_next   = 16'd0;
            phase_next = 1'b0;
            mode_next  = etre_pkg::MODE_SKIP;
            op.emit    = 1'b1;
            op.kind    = etre_pkg::KIND_VERSION;
          end else begin
            off_next = off_p1[15:0];
          end
        end
      end
      etre_pkg::MODE_SKIP: begin
      end
      default: begin
      end
    endcase

    // The last byte of a packet always returns the parser to the header.
    if (byte_data.packet_last) begin
      mode_next  = etre_pkg::MODE_HEADER;
      pos_next   = 5'd0;
      off_next   = 16'd0;
      phase_next = 1'b0;
    end
  end

  // Bytes that change nothing downstream are not queued.
  assign push = accept && (op.act != etre_pkg::ACT_NONE || op.emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= etre_pkg::MODE_HEADER;
      pos      <= 5'd0;
      off      <= 16'd0;
      tlv_type <= 16'd0;
      tlv_len  <= 16'd0;
      phase    <= 1'b0;
      opcode   <= 8'd0;
    end else if (accept) begin
      mode     <= mode_next;
      pos      <= pos_next;
      off      <= off_next;
      tlv_type <= tlv_type_next;
      tlv_len  <= tlv_len_next;
      phase    <= phase_next;
      opcode   <= opcode_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/etre_op_queue.sv =====
// Short queue of classified byte operations between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module etre_op_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire etre_pkg::byte_op_t push_op,
  input  wire logic               pop,
  output etre_pkg::byte_op_t      head,
  output etre_pkg::q_status_t     status
);

  etre_pkg::byte_op_t entries [etre_pkg::Q_DEPTH];
  logic [etre_pkg::Q_AW-1:0] wr_ptr;
  logic [etre_pkg::Q_AW-1:0] rd_ptr;
  logic [etre_pkg::Q_CW-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign status.full  = (count == etre_pkg::Q_CW'(etre_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + etre_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + etre_pkg::Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + etre_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - etre_pkg::Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/etre_back.sv =====
// Back end: applies byte operations to the field registers and builds records.
`timescale 1ns / 1ps
`default_nettype none

module etre_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire etre_pkg::byte_op_t head,
  input  wire etre_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    rec_valid,
  input  wire logic               rec_stall,
  output etre_pkg::etre_out_t     rec_data
);

  logic [7:0]  opcode, opcode_next;
  logic [31:0] flags, flags_next;
  logic [31:0] ident, ident_next;
  logic [31:0] words [4];
  logic [31:0] words_next [4];
  logic [31:0] dest, dest_next;
  logic [7:0]  prefix, prefix_next;

  logic               out_free;
  etre_pkg::etre_out_t rec;

  assign out_free = !rec_valid || !rec_stall;
  assign pop      = !q_status.empty && (!head.emit || out_free);

  always_comb begin
    opcode_next = opcode;
    flags_next  = flags;
    ident_next  = ident;
    words_next  = words;
    dest_next   = dest;
    prefix_next = prefix;
    unique case (head.act)
      etre_pkg::ACT_OPCODE: opcode_next = head.data;
      etre_pkg::ACT_FLAGS:  flags_next  = {flags[23:0], head.data};
      etre_pkg::ACT_IDENT:  ident_next  = {ident[23:0], head.data};
      etre_pkg::ACT_CLEAR: begin
        words_next[0] = 32'd0;
        words_next[1] = 32'd0;
        words_next[2] = 32'd0;
        words_next[3] = 32'd0;
        dest_next     = 32'd0;
        prefix_next   = 8'd0;
      end
      etre_pkg::ACT_WORD: begin
        words_next[head.idx] = {words[head.idx][23:0], head.data};
      end
      etre_pkg::ACT_PREFIX: prefix_next = head.data;
      etre_pkg::ACT_DEST: begin
        // Destination bytes land first byte on top; unwritten bytes stay zero.
        dest_next = dest | ({24'd0, head.data} << {2'd3 - head.idx, 3'b000});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec.record_kind   = head.kind;
    rec.opcode_value  = opcode_next;
    rec.as_number     = ident_next[15:0];
    rec.router_id     = ident_next[31:16];
    rec.header_flags  = flags_next;
    rec.value_a       = 32'd0;
    rec.value_b       = 32'd0;
    rec.value_c       = 32'd0;
    rec.route_mtu     = 24'd0;
    rec.route_hops    = 8'd0;
    rec.prefix_length = 8'd0;
    rec.destination   = 32'd0;
    unique case (head.kind)
      etre_pkg::KIND_ROUTE: begin
        rec.value_a       = words_next[0];
        rec.value_b       = words_next[1];
        rec.value_c       = words_next[2];
        rec.route_mtu     = words_next[3][31:8];
        rec.route_hops    = words_next[3][7:0];
        rec.prefix_length = prefix_next;
        rec.destination   = dest_next;
      end
      etre_pkg::KIND_PARAMS: begin
        rec.value_a = words_next[0];
        rec.value_b = words_next[1];
        rec.value_c = words_next[2];
      end
      etre_pkg::KIND_VERSION: begin
        rec.value_a = words_next[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      opcode <= opcode_next;
      flags  <= flags_next;
      ident  <= ident_next;
      words  <= words_next;
      dest   <= dest_next;
      prefix <= prefix_next;
    end
    if (pop && head.emit) begin
      rec_data <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (pop && head.emit) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/eigrp_tlv_route_extractor_unit.sv =====
// A completing byte passes the operation queue, then the output register.
// Throughput: one packet byte per cycle; the four-entry operation queue absorbs
// short output stalls, and the input stalls only when that queue is full.
// Reset (synchronous, active high) puts the parser at the start of a header and
// empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module eigrp_tlv_route_extractor_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire etre_pkg::etre_in_t byte_data,
  output logic                    rec_valid,
  input  wire logic               rec_stall,
  output etre_pkg::etre_out_t     rec_data
);

  logic                push;
  etre_pkg::byte_op_t  push_op;
  logic                pop;
  etre_pkg::byte_op_t  head;
  etre_pkg::q_status_t q_status;

  assign byte_stall = q_status.full;

  etre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_data (byte_data),
    .q_full    (q_status.full),
    .push      (push),
    .op        (push_op)
  );

  etre_op_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  etre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .rec_data (rec_data)
  );

`ifndef NO_ASSERTIONS
  // The front end must never hand an operation to a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("operation pushed into a full queue");

  // A record may only be loaded while the output register is free.
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (pop && head.emit) |-> (!rec_valid || !rec_stall))
    else $error("record overwrote a stalled output");

  // A new record always comes from an operation that was waiting in the queue.
  a_record_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(rec_valid) |-> $past(!q_status.empty))
    else $error("record appeared without a queued operation");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the EIGRP TLV route extractor: stimulus, prediction and checks.
`timescale 1ns / 1ps

module testbench;
  import etre_pkg::*;

  // Predicts the records that each transferred byte causes and checks the block's output.
  class record_board;
    parse_mode_t mode;
    bit [4:0]    hdr_pos;
    bit [15:0]   tlv_off;
    bit [15:0]   tlv_type;
    bit [15:0]   tlv_len;
    bit [7:0]    opc;
    bit [31:0]   flags;
    bit [31:0]   id_word;
    bit [31:0]   rw[5];
    bit [7:0]    pfx;
    bit          hello_ph;
    etre_out_t   expected_q[$];
    int          errors;
    int          byte_count;

    function new();
      mode = MODE_HEADER;
      hdr_pos = 0;
      tlv_off = 0;
      tlv_type = 0;
      tlv_len = 0;
      opc = 0;
      flags = 0;
      id_word = 0;
      clear_route();
      hello_ph = 0;
      errors = 0;
      byte_count = 0;
    endfunction

    function void clear_route();
      for (int i = 0; i < 5; i++) rw[i] = 0;
      pfx = 0;
    endfunction

    function void push_record(logic [1:0] kind, bit [31:0] a, bit [31:0] b, bit [31:0] c,
                              bit [23:0] mtu, bit [7:0] hop, bit [7:0] plen, bit [31:0] dst);
      etre_out_t r;
      r.record_kind   = kind;
      r.opcode_value  = opc;
      r.as_number     = id_word[15:0];
      r.router_id     = id_word[31:16];
      r.header_flags  = flags;
      r.value_a       = a;
      r.value_b       = b;
      r.value_c       = c;
      r.route_mtu     = mtu;
      r.route_hops    = hop;
      r.prefix_length = plen;
      r.destination   = dst;
      expected_q = {expected_q, r};
    endfunction

    function void note_byte(etre_in_t it);
      bit [7:0]  b;
      bit [31:0] off;
      int        w;
      bit        fin;
      b = it.data_byte;
      off = tlv_off;
      fin = 0;
      byte_count++;
      case (mode)
        MODE_HEADER: begin
          if (hdr_pos == 1) opc = b;
          else if (hdr_pos >= 4 && hdr_pos <= 7) flags[8 * (7 - int'(hdr_pos)) +: 8] = b;
          else if (hdr_pos >= 16 && hdr_pos <= 19) id_word[8 * (19 - int'(hdr_pos)) +: 8] = b;
          if (hdr_pos >= HDR_LAST_POS) begin
            hdr_pos = 0;
            tlv_off = 0;
            hello_ph = 0;
            clear_route();
            if (opc == OPC_UPDATE) mode = MODE_UPDATE;
            else if (opc == OPC_HELLO) mode = MODE_HELLO;
            else mode = MODE_SKIP;
            push_record(KIND_HEADER, '0, '0, '0, '0, '0, '0, '0);
          end else begin
            hdr_pos = hdr_pos + 5'd1;
          end
        end
        MODE_UPDATE: begin
          if (off == 0) begin
            clear_route();
            tlv_type = {b, 8'h00};
            tlv_off = 1;
          end else if (off == 1) begin
            tlv_type[7:0] = b;
            tlv_off = 2;
          end else if (off == 2) begin
            tlv_len = {b, 8'h00};
            tlv_off = 3;
          end else if (off == 3) begin
            tlv_len[7:0] = b;
            // A length that cannot even cover type and length ends parsing of the packet.
            if (tlv_len < 4) begin
              mode = MODE_SKIP;
              tlv_off = 0;
            end else if (tlv_len == 4) begin
              tlv_off = 0;
            end else begin
              tlv_off = 4;
            end
          end else begin
            if (tlv_type == ROUTE_TYPE) begin
              if (off >= 4 && off <= 19) begin
                w = int'((off - 4) >> 2);
                rw[w] = {rw[w][23:0], b};
              end else if (off == 24) begin
                pfx = b;
              end else if (off >= 25 && off <= 28) begin
                rw[4][8 * (28 - off) +: 8] = b;
              end
            end
            if (off + 1 >= tlv_len) begin
              tlv_off = 0;
              if (tlv_type == ROUTE_TYPE && tlv_len >= ROUTE_MIN_LEN)
                push_record(KIND_ROUTE, rw[0], rw[1], rw[2], rw[3][31:8], rw[3][7:0], pfx, rw[4]);
            end else begin
              tlv_off = 16'(off + 1);
            end
          end
        end
        MODE_HELLO: begin
          if (off == 0) clear_route();
          if (!hello_ph) begin
            if (off >= 4 && off <= 7) rw[0] = {rw[0][23:0], b};
            else if (off == 8 || off == 9) rw[1] = {rw[1][23:0], b};
            else if (off == 10 || off == 11) rw[2] = {rw[2][23:0], b};
            if (off >= 11) begin
              fin = 1;
              tlv_off = 0;
              hello_ph = 1;
              push_record(KIND_PARAMS, rw[0], rw[1], rw[2], '0, '0, '0, '0);
            end
          end else begin
            if (off >= 4 && off <= 7) rw[0] = {rw[0][23:0], b};
            if (off >= 7) begin
              fin = 1;
              tlv_off = 0;
              hello_ph = 0;
              mode = MODE_SKIP;
              push_record(KIND_VERSION, rw[0], '0, '0, '0, '0, '0, '0);
            end
          end
          if (!fin) tlv_off = 16'(off + 1);
        end
        default: ;
      endcase
      if (it.packet_last) begin
        mode = MODE_HEADER;
        hdr_pos = 0;
        tlv_off = 0;
        hello_ph = 0;
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_record(etre_out_t got);
      etre_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: record with none expected, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp("record_kind", want.record_kind, got.record_kind);
      cmp("opcode_value", want.opcode_value, got.opcode_value);
      cmp("as_number", want.as_number, got.as_number);
      cmp("router_id", want.router_id, got.router_id);
      cmp("header_flags", want.header_flags, got.header_flags);
      cmp("value_a", want.value_a, got.value_a);
      cmp("value_b", want.value_b, got.value_b);
      cmp("value_c", want.value_c, got.value_c);
      cmp("route_mtu", want.route_mtu, got.route_mtu);
      cmp("route_hops", want.route_hops, got.route_hops);
      cmp("prefix_length", want.prefix_length, got.prefix_length);
      cmp("destination", want.destination, got.destination);
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  etre_in_t  byte_data;
  logic      rec_valid;
  logic      rec_stall;
  etre_out_t rec_data;

  record_board board = new();
  bit [7:0]    pkt_q[$];
  bit          hold_req;
  bit          held_once;
  bit          rx_calm;
  int          stall_left;

  eigrp_tlv_route_extractor_unit dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .rec_data(rec_data)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic void add_byte(bit [7:0] v);
    pkt_q = {pkt_q, v};
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_header(bit [7:0] opcode, bit [31:0] flg, bit [31:0] idw);
    add_byte(8'($urandom_range(0, 255)));
    add_byte(opcode);
    add_random(2);
    for (int i = 3; i >= 0; i--) add_byte(flg[8 * i +: 8]);
    add_random(8);
    for (int i = 3; i >= 0; i--) add_byte(idw[8 * i +: 8]);
  endfunction

  function automatic void add_tlv(bit [15:0] typ, bit [15:0] len, int body);
    add_byte(typ[15:8]);
    add_byte(typ[7:0]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    add_random(body);
  endfunction

  function automatic void add_route(int len);
    add_tlv(ROUTE_TYPE, 16'(len), len - 4);
  endfunction

  function automatic void cut_packet(int keep);
    if (pkt_q.size() > keep) pkt_q = pkt_q[0:keep - 1];
  endfunction

  function automatic void build_update(int ntlv);
    int        r;
    bit [15:0] typ;
    add_header(OPC_UPDATE, $urandom, $urandom);
    for (int i = 0; i < ntlv; i++) begin
      r = $urandom_range(0, 99);
      typ = 16'($urandom_range(0, 65535));
      if (r < 65) add_route(29);
      else if (r < 75) add_route($urandom_range(25, 40));
      else if (r < 83) add_tlv(typ, 16'($urandom_range(4, 24)), 0);
      else if (r < 88) add_route($urandom_range(5, 24));
      else if (r < 92) add_tlv(typ, 16'd4, 0);
      else begin
        // A tiny length or a huge one ends the walk; the rest is filler.
        if (r < 96) add_tlv(typ, 16'($urandom_range(0, 3)), 0);
        else add_tlv(typ, 16'($urandom_range(4096, 65535)), 0);
        add_random($urandom_range(0, 20));
        break;
      end
      // Other TLV bodies are filled after the length field is known.
      if (r >= 75 && r < 83) add_random(int'(pkt_q[pkt_q.size() - 1]) - 4);
    end
  endfunction

  function automatic void build_random_packet();
    int r;
    int n;
    r = $urandom_range(0, 99);
    pkt_q.delete();
    if (r < 55) begin
      build_update($urandom_range(1, 4));
    end else if (r < 80) begin
      add_header(OPC_HELLO, $urandom, $urandom);
      n = $urandom_range(0, 9);
      if (n == 0) add_random(0);
      else if (n < 3) add_random($urandom_range(1, 19));
      else if (n < 8) add_random(20);
      else add_random($urandom_range(21, 30));
    end else if (r < 90) begin
      add_header(8'($urandom_range(0, 255)), $urandom, $urandom);
      add_random($urandom_range(0, 10));
    end else begin
      add_random($urandom_range(1, 19));
    end
    if (pkt_q.size() > 21 && $urandom_range(0, 99) < 15)
      cut_packet($urandom_range(1, pkt_q.size() - 1));
  endfunction

  task automatic send_byte(etre_in_t it);
    byte_valid <= 1'b1;
    byte_data <= it;
    do @(posedge clk); while (byte_stall);
    board.note_byte(it);
  endtask

  task automatic send_packet(bit burst);
    etre_in_t it;
    int       gap;
    for (int i = 0; i < pkt_q.size(); i++) begin
      it.data_byte = pkt_q[i];
      it.packet_last = (i == pkt_q.size() - 1);
      send_byte(it);
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: checks every transfer and stalls at random, with an occasional long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rec_valid && !rec_stall) board.check_record(rec_data);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        rec_stall <= 1'b1;
        stall_left--;
      end else if (rx_calm || $urandom_range(0, 99) < 80) begin
        rec_stall <= 1'b0;
      end else begin
        rec_stall <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    rec_stall = 1'b0;
    hold_req = 0;
    held_once = 0;
    rx_calm = 0;
    stall_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Header extremes: all-zero fields with an unknown opcode, then all-ones with no body.
    pkt_q.delete();
    repeat (20) add_byte(8'h00);
    add_random(3);
    send_packet(0);
    pkt_q.delete();
    repeat (20) add_byte(8'hFF);
    send_packet(0);
    // A packet that ends inside its header.
    pkt_q.delete();
    add_random(10);
    send_packet(1);
    // Hello with no body, then a full hello with a tail.
    pkt_q.delete();
    add_header(OPC_HELLO, 32'hFFFF_FFFF, 32'h0000_0000);
    send_packet(0);
    pkt_q.delete();
    add_header(OPC_HELLO, $urandom, $urandom);
    add_random(24);
    send_packet(0);
    // Minimum route, a longer route, short route TLV, then a tiny length.
    pkt_q.delete();
    add_header(OPC_UPDATE, $urandom, 32'hFFFF_FFFF);
    add_route(25);
    add_route(32);
    add_route(24);
    add_tlv(ROUTE_TYPE, 16'd2, 0);
    add_random(6);
    send_packet(0);
    // An empty TLV, a route, and a route cut off by the packet end.
    pkt_q.delete();
    add_header(OPC_UPDATE, $urandom, $urandom);
    add_tlv(16'hFFFF, 16'd4, 0);
    add_route(29);
    add_route(29);
    cut_packet(pkt_q.size() - 14);
    send_packet(0);

    while (board.byte_count < 1300) begin
      if ($urandom_range(0, 39) == 0 || (!held_once && board.byte_count > 600)) begin
        // Long receiver hold-off while back-to-back route packets keep coming.
        held_once = 1;
        hold_req = 1;
        rx_calm = 0;
        repeat (2) begin
          pkt_q.delete();
          build_update(4);
          send_packet(1);
        end
      end else begin
        rx_calm = ($urandom_range(0, 4) == 0);
        build_random_packet();
        send_packet($urandom_range(0, 3) == 0);
      end
    end
    byte_valid <= 1'b0;
    rx_calm = 1;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/etre_pkg.sv
rtl/core/etre_front.sv
rtl/core/etre_op_queue.sv
rtl/core/etre_back.sv
rtl/core/eigrp_tlv_route_extractor_unit.sv
bench/testbench.sv
